FILE: rtl/core/mlfq_pkg.sv
`timescale 1ns / 1ps
package mlfq_pkg;

  localparam int DefMaxProcs  = 16;
  localparam int DefMaxLevels = 4;
  localparam int DefTimeBits  = 32;

  localparam logic [2:0]  RstNumLevels = 3'd4;
  localparam logic [31:0] RstBoostPeriod = 32'd1000;
  localparam logic [63:0] RstSliceTable = 64'd4503668347895824;
  localparam logic [63:0] RstAllotTable = 64'd18014673391583296;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegNumLevels   = 2'd0;
  localparam logic [1:0] RegBoostPeriod = 2'd1;
  localparam logic [1:0] RegSliceTable  = 2'd2;
  localparam logic [1:0] RegAllotTable  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [3:0]  proc_slot;
    logic [31:0] burst_length;
  } mlfq_in_t;

  typedef struct packed {
    logic        ran;
    logic [3:0]  run_slot;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [31:0] time_left;
    logic [1:0]  run_level;
  } mlfq_out_t;

  // Pick one 16-bit field of a packed per-level table; levels above 3 use level 3.
  function automatic logic [15:0] table_field(input logic [63:0] tbl, input logic [2:0] lvl);
    logic [1:0] l;
    l = (lvl > 3'd3) ? 2'd3 : lvl[1:0];
    return tbl[16*l +: 16];
  endfunction

endpackage

FILE: rtl/core/mlfq_proc_mem.sv
`timescale 1ns / 1ps
// Per-process record store: remaining time and allotment use, one synchronous memory.
module mlfq_proc_mem import mlfq_pkg::*; #(
  parameter int MaxProcs = DefMaxProcs,
  parameter int TimeBits = DefTimeBits,
  localparam int SlotBits = (MaxProcs > 1) ? $clog2(MaxProcs) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [SlotBits-1:0] waddr,
  input  logic [TimeBits-1:0] wrem,
  input  logic [15:0]         wused,
  input  logic [SlotBits-1:0] raddr,
  output logic [TimeBits-1:0] rrem,
  output logic [15:0]         rused
);

  logic [TimeBits+15:0] mem [MaxProcs];
  logic [TimeBits+15:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wrem, wused};
    end
    rdata_r <= mem[raddr];
  end

  assign rrem  = rdata_r[TimeBits+15:16];
  assign rused = rdata_r[15:0];

endmodule

FILE: rtl/core/mlfq_fifo_mem.sv
`timescale 1ns / 1ps
// Level queue store: one ring of MaxProcs entries per level in one synchronous memory.
module mlfq_fifo_mem import mlfq_pkg::*; #(
  parameter int MaxProcs  = DefMaxProcs,
  parameter int MaxLevels = DefMaxLevels,
  localparam int SlotBits = (MaxProcs > 1) ? $clog2(MaxProcs) : 1,
  localparam int Depth    = MaxProcs * MaxLevels,
  localparam int AddrBits = $clog2(Depth)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [SlotBits-1:0] wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [SlotBits-1:0] rdata
);

  logic [SlotBits-1:0] mem [Depth];
  logic [SlotBits-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mlfq_scheduler_core.sv
`timescale 1ns / 1ps
// Channel  | direction | handshake
// in_      | input     | start high while busy low accepts one word
// out_     | output    | out_valid marks a one-cycle result word
// cfg_     | input     | APB write at psel & penable & pwrite & pready
//
// An arrival passes S_ARD and S_ARW; a step that runs a process passes S_BRD,
// S_PICK, S_PRD and S_EXEC, and an idle step S_BRD, S_PICK and S_DONE; a due boost
// adds S_BWR, which walks the slots one per cycle over the record memory.
// Reset (rst_n low, synchronous) empties all queues and clears arrived flags.
// Results cannot be stalled; busy stays high until a step's result word is shown.
module mlfq_scheduler_core import mlfq_pkg::*; #(
  parameter int MaxProcs  = DefMaxProcs,
  parameter int MaxLevels = DefMaxLevels,
  parameter int TimeBits  = DefTimeBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  mlfq_in_t    in_word,
  output logic        out_valid,
  output mlfq_out_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int SlotBits = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int LvlBits  = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  localparam int CntBits  = $clog2(MaxProcs + 1);
  localparam int FAddrBits = $clog2(MaxProcs * MaxLevels);
  localparam logic [TimeBits-1:0] TOne = TimeBits'(1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ARD   = 9'b000000010,
    S_ARW   = 9'b000000100,
    S_BRD   = 9'b000001000,
    S_BWR   = 9'b000010000,
    S_PICK  = 9'b000100000,
    S_PRD   = 9'b001000000,
    S_EXEC  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [2:0]  num_levels_r;
  logic [31:0] boost_period_r;
  logic [63:0] slice_table_r, allot_table_r;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_levels_r   <= RstNumLevels;
      boost_period_r <= RstBoostPeriod;
      slice_table_r  <= RstSliceTable;
      allot_table_r  <= RstAllotTable;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        RegNumLevels:   num_levels_r   <= pwdata[2:0];
        RegBoostPeriod: boost_period_r <= pwdata[31:0];
        RegSliceTable:  slice_table_r  <= pwdata;
        RegAllotTable:  allot_table_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      RegNumLevels:   prdata = {61'd0, num_levels_r};
      RegBoostPeriod: prdata = {32'd0, boost_period_r};
      RegSliceTable:  prdata = slice_table_r;
      default:        prdata = allot_table_r;
    endcase
  end

  // Effective period and top level.
  logic [TimeBits-1:0] period_m, eff_period;
  logic [LvlBits-1:0]  top_lvl;
  logic [3:0]          nl_clip;
  always_comb begin
    if (TimeBits >= 32) period_m = TimeBits'(boost_period_r);
    else                period_m = boost_period_r[TimeBits-1:0];
    eff_period = (period_m == '0) ? TOne : period_m;
    nl_clip = (num_levels_r == 3'd0) ? 4'd1 : {1'b0, num_levels_r};
    if (nl_clip > 4'(MaxLevels)) nl_clip = 4'(MaxLevels);
    top_lvl = LvlBits'(nl_clip - 4'd1);
  end

  // Control state.
  logic [MaxProcs-1:0] arrived_r, live_r;
  logic [SlotBits-1:0] head_r [MaxLevels];
  logic [SlotBits-1:0] tail_r [MaxLevels];
  logic [CntBits-1:0]  cnt_r  [MaxLevels];
  logic [TimeBits-1:0] now_r, nboost_r;
  logic                boost_init_r;
  mlfq_in_t            item_r;
  logic [SlotBits-1:0] scan_r, slot_r;
  logic [LvlBits-1:0]  lvl_r;
  logic                scan_done_r;

  // Memory ports.
  logic                pm_we;
  logic [SlotBits-1:0] pm_waddr, pm_raddr;
  logic [TimeBits-1:0] pm_wrem, pm_rrem;
  logic [15:0]         pm_wused, pm_rused;
  logic                fm_we;
  logic [FAddrBits-1:0] fm_waddr, fm_raddr;
  logic [SlotBits-1:0] fm_wdata, fm_rdata;

  mlfq_proc_mem #(.MaxProcs(MaxProcs), .TimeBits(TimeBits)) u_pmem (
    .clk, .we(pm_we), .waddr(pm_waddr), .wrem(pm_wrem), .wused(pm_wused),
    .raddr(pm_raddr), .rrem(pm_rrem), .rused(pm_rused)
  );

  mlfq_fifo_mem #(.MaxProcs(MaxProcs), .MaxLevels(MaxLevels)) u_fmem (
    .clk, .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
    .raddr(fm_raddr), .rdata(fm_rdata)
  );

  function automatic logic [FAddrBits-1:0] faddr(input logic [LvlBits-1:0] l,
                                                 input logic [SlotBits-1:0] p);
    return FAddrBits'(FAddrBits'(l) * FAddrBits'(MaxProcs) + FAddrBits'(p));
  endfunction

  function automatic logic [SlotBits-1:0] wrap_inc(input logic [SlotBits-1:0] p);
    return (32'(p) == MaxProcs - 1) ? '0 : p + SlotBits'(1);
  endfunction

  // Highest non-empty level at or below the top.
  logic                pick_ok;
  logic [LvlBits-1:0]  pick_lvl;
  always_comb begin
    pick_ok  = 1'b0;
    pick_lvl = '0;
    for (int l = 0; l < MaxLevels; l++) begin
      if (LvlBits'(l) <= top_lvl && cnt_r[l] != '0) begin
        pick_ok  = 1'b1;
        pick_lvl = LvlBits'(l);
      end
    end
  end

  // Run arithmetic, done in S_EXEC from the registered record.
  logic [TimeBits-1:0] slice_t, exec_t, dist_t, rem_new;
  logic [15:0]         slice_f, allot_f, used_new;
  logic [16:0]         used_sum;
  logic                demote;
  always_comb begin
    slice_f = table_field(slice_table_r, 3'(lvl_r));
    allot_f = table_field(allot_table_r, 3'(lvl_r));
    slice_t = (slice_f == 16'd0) ? TOne : TimeBits'(slice_f);
    if (TimeBits < 16) slice_t = (slice_f > 16'(2**TimeBits - 1)) ? '1 : slice_t;
    exec_t = (slice_t > pm_rrem) ? pm_rrem : slice_t;
    dist_t = nboost_r - now_r;
    if (exec_t >= dist_t) exec_t = dist_t;
    rem_new = pm_rrem - exec_t;
    if (exec_t > TimeBits'(16'hFFFF)) used_sum = 17'h1FFFF;
    else used_sum = {1'b0, pm_rused} + 17'(exec_t);
    used_new = used_sum[16] ? 16'hFFFF : used_sum[15:0];
    demote = used_new >= allot_f;
  end

  logic arr_ok;
  assign arr_ok = (32'(item_r.proc_slot) < MaxProcs) && (item_r.burst_length != '0)
                  && !(arrived_r[SlotBits'(item_r.proc_slot)] && live_r[SlotBits'(item_r.proc_slot)]);

  logic [SlotBits-1:0] ar_slot;
  assign ar_slot = SlotBits'(item_r.proc_slot);

  logic [LvlBits-1:0] push_lvl;
  assign push_lvl = (demote && lvl_r != '0) ? lvl_r - LvlBits'(1) : lvl_r;

  mlfq_out_t out_r;
  logic      out_valid_r;

  always_comb begin
    state_nxt = state_r;
    pm_we = 1'b0; pm_waddr = slot_r; pm_wrem = rem_new; pm_wused = used_new;
    pm_raddr = scan_r;
    fm_we = 1'b0; fm_waddr = faddr(top_lvl, tail_r[top_lvl]); fm_wdata = scan_r;
    fm_raddr = faddr(pick_lvl, head_r[pick_lvl]);
    if (demote) pm_wused = 16'd0;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = in_word.kind ? S_BRD : S_ARD;
      S_ARD: state_nxt = S_ARW;
      S_ARW: begin
        if (arr_ok) begin
          pm_we = 1'b1; pm_waddr = ar_slot;
          pm_wrem = TimeBits'(item_r.burst_length); pm_wused = 16'd0;
          fm_we = (cnt_r[top_lvl] < CntBits'(MaxProcs));
          fm_wdata = ar_slot;
        end
        state_nxt = S_IDLE;
      end
      S_BRD: state_nxt = (dist_t == '0) ? S_BWR : S_PICK;
      S_BWR: begin
        // One slot per cycle: clear its allotment use and requeue if active.
        pm_we = 1'b1; pm_waddr = scan_r; pm_wrem = pm_rrem; pm_wused = 16'd0;
        pm_raddr = wrap_inc(scan_r);
        fm_we = arrived_r[scan_r] && live_r[scan_r];
        if (scan_done_r) state_nxt = S_PICK;
      end
      // The queue head is read at the end of S_PICK and shows in S_PRD.
      S_PICK: state_nxt = pick_ok ? S_PRD : S_DONE;
      S_PRD: begin
        pm_raddr = fm_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        pm_we = 1'b1;
        fm_we = rem_new != '0;
        fm_waddr = faddr(push_lvl, tail_r[push_lvl]);
        fm_wdata = slot_r;
        state_nxt = S_IDLE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arrived_r   <= '0;
      live_r      <= '0;
      now_r       <= '0;
      boost_init_r <= 1'b1;
      nboost_r    <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      scan_done_r <= 1'b0;
      for (int l = 0; l < MaxLevels; l++) begin
        head_r[l] <= '0; tail_r[l] <= '0; cnt_r[l] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (boost_init_r) begin
        nboost_r     <= eff_period;
        boost_init_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (start) begin
          item_r <= in_word;
          scan_r <= '0;
          scan_done_r <= (MaxProcs == 1);
        end
        S_ARD: ;
        S_ARW: if (arr_ok) begin
          arrived_r[ar_slot] <= 1'b1;
          live_r[ar_slot]    <= 1'b1;
          if (cnt_r[top_lvl] < CntBits'(MaxProcs)) begin
            tail_r[top_lvl] <= wrap_inc(tail_r[top_lvl]);
            cnt_r[top_lvl]  <= cnt_r[top_lvl] + CntBits'(1);
          end
        end
        S_BRD: if (dist_t == '0) begin
          for (int l = 0; l < MaxLevels; l++) begin
            head_r[l] <= '0; tail_r[l] <= '0; cnt_r[l] <= '0;
          end
          nboost_r <= nboost_r + eff_period;
        end
        S_BWR: begin
          if (arrived_r[scan_r] && live_r[scan_r]) begin
            tail_r[top_lvl] <= wrap_inc(tail_r[top_lvl]);
            cnt_r[top_lvl]  <= cnt_r[top_lvl] + CntBits'(1);
          end
          scan_r <= wrap_inc(scan_r);
          scan_done_r <= (32'(scan_r) == MaxProcs - 2);
        end
        S_PICK: begin
          lvl_r <= pick_lvl;
          if (pick_ok) begin
            head_r[pick_lvl] <= wrap_inc(head_r[pick_lvl]);
            cnt_r[pick_lvl]  <= cnt_r[pick_lvl] - CntBits'(1);
          end
        end
        S_PRD: slot_r <= fm_rdata;
        S_EXEC: begin
          now_r <= now_r + exec_t;
          live_r[slot_r] <= (rem_new != '0);
          if (rem_new != '0) begin
            tail_r[push_lvl] <= wrap_inc(tail_r[push_lvl]);
            cnt_r[push_lvl]  <= cnt_r[push_lvl] + CntBits'(1);
          end
          out_valid_r        <= 1'b1;
          out_r.ran          <= 1'b1;
          out_r.run_slot     <= 4'(slot_r);
          out_r.start_time   <= 32'(now_r);
          out_r.end_time     <= 32'(now_r + exec_t);
          out_r.time_left    <= 32'(rem_new);
          out_r.run_level    <= 2'(lvl_r);
        end
        S_DONE: begin
          now_r <= now_r + TOne;
          out_valid_r        <= 1'b1;
          out_r.ran          <= 1'b0;
          out_r.run_slot     <= 4'd0;
          out_r.start_time   <= 32'(now_r);
          out_r.end_time     <= 32'(now_r + TOne);
          out_r.time_left    <= 32'd0;
          out_r.run_level    <= 2'd0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef ASSERT_OFF
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_res_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |=> out_valid && out_word.ran)
    else $error("run gave no result");
  a_no_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_EXEC || state_r == S_DONE))
    else $error("stray result");
  a_busy_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
`endif

endmodule

FILE: tb/sv/tb_mlfq_scheduler_core.sv
`timescale 1ns / 1ps
module tb_mlfq_scheduler_core;
  import mlfq_pkg::*;

  localparam logic KindArrive = 1'b0;
  localparam logic KindStep   = 1'b1;
  localparam int   CycleLimit = 400000;
  localparam int   SettleCycles = 40;

  typedef struct {
    mlfq_in_t word;
    bit       drain_first;
  } pending_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  mlfq_in_t    in_word;
  logic        out_valid;
  mlfq_out_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  mlfq_scheduler_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Stimulus and expected schedule records.
  pending_t  pending_q[$];
  mlfq_out_t sched_q[$];
  int        sender_idle_pct;
  int        fail_count;
  int        cycle_count;
  int        n_steps, n_runs, n_idle, n_boosts, n_arrivals;

  // Scheduler state mirror.
  logic [2:0]  lvl_cfg;
  logic [31:0] period_cfg;
  logic [63:0] slice_cfg;
  logic [63:0] allot_cfg;
  logic [31:0] rem_time[16];
  bit          has_arrived[16];
  logic [15:0] used_allot[16];
  logic [3:0]  ready_q[4][$];
  logic [31:0] clock_now;
  logic [31:0] boost_at;

  function automatic logic [31:0] live_period();
    return (period_cfg == 0) ? 32'd1 : period_cfg;
  endfunction

  function automatic int live_levels();
    int n;
    n = lvl_cfg;
    if (n == 0) n = 1;
    if (n > 4) n = 4;
    return n;
  endfunction

  function automatic bit slot_busy(int s);
    return has_arrived[s] && rem_time[s] != 0;
  endfunction

  function automatic void sched_reset();
    lvl_cfg = RstNumLevels;
    period_cfg = RstBoostPeriod;
    slice_cfg = RstSliceTable;
    allot_cfg = RstAllotTable;
    for (int s = 0; s < 16; s++) begin
      has_arrived[s] = 0;
      rem_time[s] = '0;
      used_allot[s] = '0;
    end
    for (int l = 0; l < 4; l++) ready_q[l].delete();
    clock_now = '0;
    boost_at = live_period();
  endfunction

  function automatic void sched_push(int l, logic [3:0] s);
    if (ready_q[l].size() < 16) ready_q[l].push_back(s);
  endfunction

  // Apply one accepted word to the mirror; a step queues its expected record.
  function automatic void sched_apply(mlfq_in_t w);
    int top;
    int s;
    logic [31:0] run_len, to_boost, start_t;
    logic [16:0] sum;
    logic [15:0] quota;
    mlfq_out_t r;
    top = live_levels() - 1;
    if (w.kind == KindArrive) begin
      s = w.proc_slot;
      if (w.burst_length == 0 || slot_busy(s)) return;
      has_arrived[s] = 1;
      rem_time[s] = w.burst_length;
      used_allot[s] = '0;
      sched_push(top, w.proc_slot);
      n_arrivals++;
      return;
    end
    n_steps++;
    if (boost_at == clock_now) begin
      n_boosts++;
      for (int l = 0; l < 4; l++) ready_q[l].delete();
      for (int i = 0; i < 16; i++) begin
        used_allot[i] = '0;
        if (slot_busy(i)) sched_push(top, 4'(i));
      end
      boost_at = boost_at + live_period();
    end
    for (int l = top; l >= 0; l--) begin
      if (ready_q[l].size() == 0) continue;
      s = ready_q[l].pop_front();
      run_len = slice_cfg[16*l +: 16];
      if (run_len == 0) run_len = 1;
      if (run_len > rem_time[s]) run_len = rem_time[s];
      to_boost = boost_at - clock_now;
      if (run_len >= to_boost) run_len = to_boost;
      rem_time[s] = rem_time[s] - run_len;
      start_t = clock_now;
      clock_now = clock_now + run_len;
      sum = {1'b0, used_allot[s]} + ((run_len > 32'hFFFF) ? 17'h1FFFF : run_len[16:0]);
      used_allot[s] = (sum > 17'hFFFF) ? 16'hFFFF : sum[15:0];
      quota = allot_cfg[16*l +: 16];
      if (rem_time[s] != 0) begin
        if (used_allot[s] >= quota) begin
          used_allot[s] = '0;
          sched_push((l == 0) ? 0 : l - 1, 4'(s));
        end else begin
          sched_push(l, 4'(s));
        end
      end
      r.ran = 1'b1;
      r.run_slot = 4'(s);
      r.start_time = start_t;
      r.end_time = clock_now;
      r.time_left = rem_time[s];
      r.run_level = 2'(l);
      sched_q.push_back(r);
      n_runs++;
      return;
    end
    r.ran = 1'b0;
    r.run_slot = '0;
    r.start_time = clock_now;
    clock_now = clock_now + 1;
    r.end_time = clock_now;
    r.time_left = '0;
    r.run_level = '0;
    sched_q.push_back(r);
    n_idle++;
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Driver: presents queued words, idles at random, and can hold a word
  // until every outstanding record has come back.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sched_apply(in_word);
      if (!start || !busy) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
            !(pending_q[0].drain_first && sched_q.size() != 0)) begin
          in_word <= pending_q[0].word;
          void'(pending_q.pop_front());
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result word is checked against the oldest expectation.
  always @(posedge clk) begin
    mlfq_out_t e;
    if (rst_n && out_valid) begin
      if (sched_q.size() == 0) begin
        $error("unexpected result word %p", out_word);
        fail_count++;
      end else begin
        e = sched_q.pop_front();
        if (out_word.ran !== e.ran) begin
          $error("ran: expected %0d, got %0d", e.ran, out_word.ran);
          fail_count++;
        end
        if (out_word.run_slot !== e.run_slot) begin
          $error("run_slot: expected %0d, got %0d", e.run_slot, out_word.run_slot);
          fail_count++;
        end
        if (out_word.start_time !== e.start_time) begin
          $error("start_time: expected %0d, got %0d", e.start_time, out_word.start_time);
          fail_count++;
        end
        if (out_word.end_time !== e.end_time) begin
          $error("end_time: expected %0d, got %0d", e.end_time, out_word.end_time);
          fail_count++;
        end
        if (out_word.time_left !== e.time_left) begin
          $error("time_left: expected %0d, got %0d", e.time_left, out_word.time_left);
          fail_count++;
        end
        if (out_word.run_level !== e.run_level) begin
          $error("run_level: expected %0d, got %0d", e.run_level, out_word.run_level);
          fail_count++;
        end
      end
    end
  end

  // Queue one word for the driver.
  task automatic add_word(logic kind, logic [3:0] slot, logic [31:0] burst, bit drain);
    pending_t p;
    p.word.kind = kind;
    p.word.proc_slot = slot;
    p.word.burst_length = burst;
    p.drain_first = drain;
    pending_q.push_back(p);
  endtask

  // Write one register over the configuration port and mirror it.
  task automatic reg_write(logic [1:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegNumLevels:   lvl_cfg = value[2:0];
      RegBoostPeriod: period_cfg = value[31:0];
      RegSliceTable:  slice_cfg = value;
      RegAllotTable:  allot_cfg = value;
    endcase
  endtask

  // Wait for the driver to run dry, all records to arrive and the block to settle.
  task automatic drain_all();
    while (pending_q.size() != 0 || start || sched_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random mix: mostly steps plus arrivals with mostly short bursts, some noise.
  task automatic add_random(int count);
    int pick;
    logic [31:0] burst;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) burst = $urandom_range(1, 60);
      else if (pick < 90) burst = $urandom;
      else if (pick < 95) burst = 32'hFFFF_FFFF;
      else burst = '0;
      if ($urandom_range(99) < 38)
        add_word(KindArrive, 4'($urandom), burst, 0);
      else
        add_word(KindStep, 4'($urandom), $urandom, i == count / 2);
    end
  endtask

  initial begin
    logic [2:0]  lv[6];
    logic [31:0] per[6];
    lv  = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd2, 3'd3};
    per = '{32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd37, 32'd500};
    rst_n = 1'b0;
    start = 1'b0;
    in_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sender_idle_pct = 26;
    fail_count = 0;
    cycle_count = 0;
    n_steps = 0; n_runs = 0; n_idle = 0; n_boosts = 0; n_arrivals = 0;
    sched_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty step, extremes of slot and burst, ignored arrivals,
    // a finished slot arriving again.
    add_word(KindStep, 4'hF, 32'hFFFF_FFFF, 0);
    add_word(KindArrive, 4'd0, 32'd1, 0);
    add_word(KindArrive, 4'd15, 32'hFFFF_FFFF, 0);
    add_word(KindArrive, 4'd3, 32'd0, 0);
    add_word(KindArrive, 4'd15, 32'd5, 0);
    add_word(KindStep, 4'd0, 32'd0, 0);
    add_word(KindStep, 4'd0, 32'd0, 0);
    add_word(KindArrive, 4'd0, 32'd20, 0);
    add_word(KindArrive, 4'd7, 32'd2, 0);
    for (int i = 0; i < 12; i++) add_word(KindStep, 4'($urandom), $urandom, 0);
    drain_all();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      sender_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 56 : 0;
      reg_write(RegNumLevels, {61'd0, lv[ph]});
      reg_write(RegBoostPeriod, {32'd0, per[ph]});
      reg_write(RegSliceTable, (ph == 2) ? 64'd0 : (ph == 3) ? '1 :
                (ph == 0) ? RstSliceTable : {$urandom, $urandom} & 64'h00FF_003F_001F_000F);
      reg_write(RegAllotTable, (ph == 2) ? 64'd0 : (ph == 3) ? '1 :
                (ph == 0) ? RstAllotTable : {$urandom, $urandom} & 64'h01FF_00FF_007F_003F);
      add_random(222);
      drain_all();
    end

    $display("Covered %0d arrivals and %0d steps (%0d runs, %0d idle ticks, %0d boosts)",
             n_arrivals, n_steps, n_runs, n_idle, n_boosts);
    $display("over 6 register settings with sender gaps of 26, 56 and 0 percent.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
